// File: sv/qsdr_pkg.sv
package qsdr_pkg;

    localparam int KEY_W         = 16;
    localparam int PAY_W         = 32;
    localparam int REC_W         = KEY_W + PAY_W;   // {payload, score}
    localparam int DATA_W        = 48;              // REC_W padded to whole bytes
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [3:0] {
        S_LOAD,    // collecting records
        S_POP,     // pop a range off the stack
        S_POPW,    // range in hand, read middle record
        S_MID,     // middle record in hand, read end record
        S_END,     // end record written to middle
        S_ENDW,    // middle record written to end, start scan
        S_LO,      // low pointer scan
        S_HI,      // high pointer scan
        S_SW,      // second half of an exchange
        S_FIN,     // pivot slot record moved to end
        S_FIN2,    // pivot placed, push right part
        S_PUSHL,   // push left part
        S_EMIT,    // issue read of next sorted record
        S_EDAT     // load output register
    } t_state;

    typedef struct packed {
        logic key_ge;   // record key >= pivot key (signed)
        logic ptr_lt;   // pointer a < pointer b
    } t_cmp;

endpackage

// File: sv/quicksort_descending_records.sv
// quicksort_descending_records
//
// Collects records (signed 16-bit score, 32-bit payload) on the s_axis side
// until a request with tlast high arrives, sorts the set by score, largest
// first, and sends it out on the m_axis side with tlast on the final record.
// tuser on the output is high on every record of a set that lost records
// because more than MAX_ITEMS arrived; extra records are dropped, but a tlast
// request still closes the set and starts the sort.
//
// Loading accepts one record per cycle. After tlast, s_axis_tready stays low
// while one record RAM port pair and one compare unit run the partition
// sequencer: a stack pop and a middle-to-end swap set up each range, the
// pointer scans compare one key against the pivot at a time, S_SW finishes
// each exchange, and S_FIN and S_FIN2 place the pivot before the two parts
// are pushed. Output reads each record and then loads the output register
// once that register is free; a stall holds the output register and the
// sequencer waits. The last record leaves through the output register, so
// loading of the next set may start while it waits to be taken.
//
// Reset (synchronous, active low) empties the set and clears the output.

module quicksort_descending_records
    import qsdr_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [15:0] score, [47:16] payload
    input  logic              s_axis_tlast,   // last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [15:0] sorted_score, [47:16] sorted_payload
    output logic              m_axis_tlast,   // last_out
    output logic              m_axis_tuser    // dropped
);

    localparam int AW     = $clog2(MAX_ITEMS);        // record address
    localparam int CW     = $clog2(MAX_ITEMS + 1);    // counts and pointers
    localparam int SD     = MAX_ITEMS / 2;            // disjoint ranges of two or more
    localparam int SAW    = (SD > 1) ? $clog2(SD) : 1;
    localparam int SDEPTH = 1 << SAW;
    localparam int SPW    = $clog2(SD + 1);
    localparam int SW     = 2 * CW;                   // {start, length}

    t_state r_state, n_state;

    // control state
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_ovf, n_ovf;
    logic [SPW-1:0] r_sp, n_sp;
    logic           r_ovalid, n_ovalid;

    // datapath registers
    logic [CW-1:0]           r_start, n_start;
    logic [CW-1:0]           r_n, n_n;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi1, n_hi1;     // high pointer plus one
    logic [CW-1:0]           r_idx, n_idx;
    logic signed [KEY_W-1:0] r_pk, n_pk;
    logic [REC_W-1:0]        r_rec_a, n_rec_a; // pivot record
    logic [REC_W-1:0]        r_rec_b, n_rec_b; // record held for an exchange
    logic [REC_W-1:0]        r_odata, n_odata;
    logic                    r_olast, n_olast;
    logic                    r_ouser, n_ouser;

    // memory ports
    logic             rec_we;
    logic [AW-1:0]    rec_waddr, rec_raddr;
    logic [REC_W-1:0] rec_wdata, rec_rdata;
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr, stk_raddr;
    logic [SW-1:0]    stk_wdata, stk_rdata;

    // compare unit
    logic [CW-1:0] cmp_a, cmp_b;
    t_cmp          cmp;

    logic                    in_acc, store, emit_last, out_free;
    logic [CW-1:0]           cnt_after, mid_pop, mid_r, end_r, lo_p1, hi_m1, hi_m2;
    logic [CW-1:0]           stk_start, stk_len, rn, ln;
    logic [SPW-1:0]          sp_m1;
    logic signed [KEY_W-1:0] rd_key;

    qsdr_ram #(.WIDTH(REC_W), .DEPTH(MAX_ITEMS), .ADDR_W(AW)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata)
    );

    qsdr_ram #(.WIDTH(SW), .DEPTH(SDEPTH), .ADDR_W(SAW)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    qsdr_cmp #(.PTR_W(CW)) u_cmp (
        .i_key   (rd_key),
        .i_pivot (r_pk),
        .i_a     (cmp_a),
        .i_b     (cmp_b),
        .o_res   (cmp)
    );

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign store         = (r_cnt < CW'(MAX_ITEMS));
    assign cnt_after     = store ? r_cnt + CW'(1) : r_cnt;

    assign rd_key    = signed'(rec_rdata[KEY_W-1:0]);
    assign stk_start = stk_rdata[SW-1:CW];
    assign stk_len   = stk_rdata[CW-1:0];
    assign mid_pop   = stk_start + (stk_len >> 1);
    assign mid_r     = r_start + (r_n >> 1);
    assign end_r     = r_start + r_n - CW'(1);
    assign lo_p1     = r_lo + CW'(1);
    assign hi_m1     = r_hi1 - CW'(1);
    assign hi_m2     = r_hi1 - CW'(2);
    assign sp_m1     = r_sp - SPW'(1);
    assign rn        = end_r - r_lo;       // right part length
    assign ln        = r_lo - r_start;     // left part length
    assign emit_last = (r_idx == r_cnt - CW'(1));
    assign out_free  = !r_ovalid || m_axis_tready;

    // pointer operands: next low pointer against bound, or low against next bound
    always_comb begin
        cmp_a = lo_p1;
        cmp_b = r_hi1;
        if (r_state == S_HI) begin
            cmp_a = r_lo;
            cmp_b = hi_m1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && s_axis_tlast) begin
                    n_state = (cnt_after < CW'(2)) ? S_EMIT : S_POP;
                end
            end
            S_POP:   n_state = (r_sp == '0) ? S_EMIT : S_POPW;
            S_POPW:  n_state = S_MID;
            S_MID:   n_state = S_END;
            S_END:   n_state = S_ENDW;
            S_ENDW:  n_state = S_LO;
            S_LO: begin
                if (cmp.key_ge) begin
                    n_state = cmp.ptr_lt ? S_LO : S_FIN;
                end else begin
                    n_state = S_HI;
                end
            end
            S_HI: begin
                if (!cmp.key_ge) begin
                    n_state = cmp.ptr_lt ? S_HI : S_FIN;
                end else begin
                    n_state = S_SW;
                end
            end
            S_SW:    n_state = cmp.ptr_lt ? S_LO : S_FIN;
            S_FIN:   n_state = S_FIN2;
            S_FIN2:  n_state = S_PUSHL;
            S_PUSHL: n_state = S_POP;
            S_EMIT:  n_state = out_free ? S_EDAT : S_EMIT;
            S_EDAT:  n_state = emit_last ? S_LOAD : S_EMIT;
            default: n_state = S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_sp      = r_sp;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_start   = r_start;
        n_n       = r_n;
        n_lo      = r_lo;
        n_hi1     = r_hi1;
        n_idx     = r_idx;
        n_pk      = r_pk;
        n_rec_a   = r_rec_a;
        n_rec_b   = r_rec_b;
        n_odata   = r_odata;
        n_olast   = r_olast;
        n_ouser   = r_ouser;
        rec_we    = 1'b0;
        rec_waddr = '0;
        rec_wdata = rec_rdata;
        rec_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = {r_start, r_n};
        stk_raddr = '0;
        case (r_state)
            S_LOAD: begin
                n_idx = '0;
                if (in_acc) begin
                    if (store) begin
                        rec_we    = 1'b1;
                        rec_waddr = r_cnt[AW-1:0];
                        rec_wdata = s_axis_tdata[REC_W-1:0];
                        n_cnt     = cnt_after;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast && cnt_after >= CW'(2)) begin
                        // whole set is the first range
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = {CW'(0), cnt_after};
                        n_sp      = SPW'(1);
                    end
                end
            end
            S_POP: begin
                n_idx     = '0;
                stk_raddr = sp_m1[SAW-1:0];
                if (r_sp != '0) begin
                    n_sp = sp_m1;
                end
            end
            S_POPW: begin
                n_start   = stk_start;
                n_n       = stk_len;
                rec_raddr = mid_pop[AW-1:0];
            end
            S_MID: begin
                n_rec_a   = rec_rdata;
                n_pk      = rd_key;
                rec_raddr = end_r[AW-1:0];
            end
            S_END: begin
                rec_we    = 1'b1;
                rec_waddr = mid_r[AW-1:0];
            end
            S_ENDW: begin
                rec_we    = 1'b1;
                rec_waddr = end_r[AW-1:0];
                rec_wdata = r_rec_a;
                n_lo      = r_start;
                n_hi1     = end_r;
                rec_raddr = r_start[AW-1:0];
            end
            S_LO: begin
                if (cmp.key_ge) begin
                    n_lo      = lo_p1;
                    rec_raddr = lo_p1[AW-1:0];
                end else begin
                    n_rec_b   = rec_rdata;
                    rec_raddr = hi_m1[AW-1:0];
                end
            end
            S_HI: begin
                if (!cmp.key_ge) begin
                    n_hi1     = hi_m1;
                    rec_raddr = cmp.ptr_lt ? hi_m2[AW-1:0] : r_lo[AW-1:0];
                end else begin
                    // exchange: low record to high slot now, high record next
                    rec_we    = 1'b1;
                    rec_waddr = hi_m1[AW-1:0];
                    rec_wdata = r_rec_b;
                    n_rec_b   = rec_rdata;
                end
            end
            S_SW: begin
                rec_we    = 1'b1;
                rec_waddr = r_lo[AW-1:0];
                rec_wdata = r_rec_b;
                n_lo      = lo_p1;
                rec_raddr = lo_p1[AW-1:0];
            end
            S_FIN: begin
                rec_we    = 1'b1;
                rec_waddr = end_r[AW-1:0];
            end
            S_FIN2: begin
                rec_we    = 1'b1;
                rec_waddr = r_lo[AW-1:0];
                rec_wdata = r_rec_a;
                if (rn >= CW'(2)) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_sp[SAW-1:0];
                    stk_wdata = {lo_p1, rn};
                    n_sp      = r_sp + SPW'(1);
                end
            end
            S_PUSHL: begin
                if (ln >= CW'(2)) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_sp[SAW-1:0];
                    stk_wdata = {r_start, ln};
                    n_sp      = r_sp + SPW'(1);
                end
            end
            S_EMIT: begin
                rec_raddr = r_idx[AW-1:0];
            end
            S_EDAT: begin
                n_ovalid = 1'b1;
                n_odata  = rec_rdata;
                n_olast  = emit_last;
                n_ouser  = r_ovf;
                if (emit_last) begin
                    n_cnt = '0;
                    n_ovf = 1'b0;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_n     <= n_n;
        r_lo    <= n_lo;
        r_hi1   <= n_hi1;
        r_idx   <= n_idx;
        r_pk    <= n_pk;
        r_rec_a <= n_rec_a;
        r_rec_b <= n_rec_b;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_ouser <= n_ouser;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = DATA_W'(r_odata);
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

endmodule

// File: sv/qsdr_ram.sv
module qsdr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/qsdr_cmp.sv
module qsdr_cmp
    import qsdr_pkg::*;
#(
    parameter int PTR_W = 7
) (
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [KEY_W-1:0] i_pivot,
    input  logic        [PTR_W-1:0] i_a,
    input  logic        [PTR_W-1:0] i_b,
    output t_cmp                    o_res
);

    // one signed key compare and one pointer compare per cycle
    always_comb begin
        o_res.key_ge = (i_key >= i_pivot);
        o_res.ptr_lt = (i_a < i_b);
    end

endmodule

// File: sv/qsdr_chk.sv
module qsdr_chk
    import qsdr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [DATA_W-1:0] s_axis_tdata,
    input logic              s_axis_tlast,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    logic                    r_in_run;
    logic signed [KEY_W-1:0] r_prev_score;
    logic                    r_prev_user;
    logic                    out_acc;
    logic signed [KEY_W-1:0] out_score;

    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign out_score = signed'(m_axis_tdata[KEY_W-1:0]);

    // tracks the previous record of the current output run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (out_acc) begin
            r_in_run <= !m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev_score <= out_score;
            r_prev_user  <= m_axis_tuser;
        end
    end

    // scores leave largest first within a run
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_in_run |-> out_score <= r_prev_score)
        else $error("sorted run not descending");

    // drop flag is the same on every record of a run
    a_user_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_in_run |-> m_axis_tuser == r_prev_user)
        else $error("drop flag changed within a run");

    // closing request stops input while the set is sorted
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after tlast");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind quicksort_descending_records qsdr_chk u_qsdr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: verif/tb_quicksort_descending_records.sv
`timescale 1ns / 100ps

// Record sorter bench. Records go in as sets closed by tlast. A local quicksort
// (middle pivot moved to the range end, same partition walk and range order)
// gives the exact, unstable output order. Each returned record is checked field
// by field against the head of the expected queue.

module tb_quicksort_descending_records;

    import qsdr_pkg::*;

    localparam int CAP          = MAX_ITEMS_DEF;
    localparam int IDLE_LIMIT   = 20000;   // covers the worst-case sort plus the long hold
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int TARGET_ITEMS = 480;

    typedef struct packed {
        logic signed [KEY_W-1:0] score;
        logic [PAY_W-1:0]        payload;
        logic                    is_last;
    } t_rec_req;

    typedef struct packed {
        logic signed [KEY_W-1:0] score;
        logic [PAY_W-1:0]        payload;
        logic                    is_last;
        logic                    dropped;
    } t_sorted_rec;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;   // [15:0] score, [47:16] payload
    logic              s_axis_tlast  = 1'b0; // last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;         // [15:0] sorted_score, [47:16] sorted_payload
    logic              m_axis_tlast;         // last_out
    logic              m_axis_tuser;         // dropped

    wire in_fire  = s_axis_tvalid && s_axis_tready;
    wire out_fire = m_axis_tvalid && m_axis_tready;

    // stimulus and expectations
    t_rec_req    pending_records[$];
    t_rec_req    next_req;
    t_sorted_rec expected_sorted[$];
    int          mismatches = 0;
    int          items_queued = 0;

    // mirror of the record store
    logic signed [KEY_W-1:0] held_score   [CAP];
    logic [PAY_W-1:0]        held_payload [CAP];
    int                      held_count   = 0;
    logic                    held_dropped = 1'b0;

    // flow control
    int burst_left = 0;
    int gap_left   = 0;
    int stall_mode = 0;
    int window_left = 0;
    int hold_left  = 0;
    logic hold_done = 1'b0;
    int results_seen = 0;
    int idle_cycles  = 0;

    quicksort_descending_records dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- sorter model

    function automatic void swap_held(int a, int b);
        logic signed [KEY_W-1:0] k;
        logic [PAY_W-1:0]        p;
        k = held_score[a];
        p = held_payload[a];
        held_score[a]   = held_score[b];
        held_payload[a] = held_payload[b];
        held_score[b]   = k;
        held_payload[b] = p;
    endfunction

    // returns the final pivot slot
    function automatic int split_range(int base, int len);
        int tail, lo, hi;
        logic signed [KEY_W-1:0] pivot;
        tail = base + len - 1;
        swap_held(base + len / 2, tail);
        pivot = held_score[tail];
        lo = base;
        hi = base + len - 2;
        while (lo <= hi) begin
            if (held_score[lo] >= pivot)
                lo++;
            else if (held_score[hi] < pivot)
                hi--;
            else
                swap_held(lo, hi);
        end
        swap_held(lo, tail);
        return lo;
    endfunction

    function automatic void sort_held(int count);
        int range_base[$];
        int range_len[$];
        int b, n, p, ln, rn;
        if (count < 2)
            return;
        range_base = {range_base, 0};
        range_len  = {range_len, count};
        while (range_len.size() != 0) begin
            b  = range_base.pop_back();
            n  = range_len.pop_back();
            p  = split_range(b, n);
            ln = p - b;
            rn = n - ln - 1;
            // right part pushed first so the left part is worked first
            if (rn >= 2) begin
                range_base = {range_base, p + 1};
                range_len  = {range_len, rn};
            end
            if (ln >= 2) begin
                range_base = {range_base, b};
                range_len  = {range_len, ln};
            end
        end
    endfunction

    // one accepted request: store it, and on tlast queue the sorted set
    function automatic void take_record(logic signed [KEY_W-1:0] score,
                                        logic [PAY_W-1:0] payload, logic is_last);
        t_sorted_rec r;
        if (held_count < CAP) begin
            held_score[held_count]   = score;
            held_payload[held_count] = payload;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!is_last)
            return;
        sort_held(held_count);
        for (int i = 0; i < held_count; i++) begin
            r.score   = held_score[i];
            r.payload = held_payload[i];
            r.is_last = (i == held_count - 1);
            r.dropped = held_dropped;
            expected_sorted = {expected_sorted, r};
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_record(int score, logic [PAY_W-1:0] payload, logic is_last);
        t_rec_req r;
        r.score   = KEY_W'(score);
        r.payload = payload;
        r.is_last = is_last;
        pending_records = {pending_records, r};
        items_queued++;
    endfunction

    // key_span 0: full-range keys; otherwise keys in a narrow band to force ties
    function automatic void queue_set(int size, int key_span);
        int k;
        for (int i = 0; i < size; i++) begin
            if (key_span == 0)
                k = $signed(KEY_W'($urandom));
            else
                k = $urandom_range(0, key_span) - key_span / 2;
            queue_record(k, $urandom, i == size - 1);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_result();
        t_sorted_rec want;
        logic signed [KEY_W-1:0] got_score;
        logic [PAY_W-1:0]        got_payload;
        got_score   = m_axis_tdata[KEY_W-1:0];
        got_payload = m_axis_tdata[KEY_W +: PAY_W];
        if (expected_sorted.size() == 0) begin
            report_mismatch($sformatf("unexpected record score %0d payload %h",
                                      got_score, got_payload));
            return;
        end
        want = expected_sorted.pop_front();
        if (got_score != want.score)
            report_mismatch($sformatf("score %0d, expected %0d", got_score, want.score));
        if (got_payload != want.payload)
            report_mismatch($sformatf("payload %h, expected %h", got_payload, want.payload));
        if (m_axis_tlast != want.is_last)
            report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, want.is_last));
        if (m_axis_tuser != want.dropped)
            report_mismatch($sformatf("dropped %b, expected %b", m_axis_tuser, want.dropped));
    endtask

    function automatic logic pick_ready(int mode, int phase);
        case (mode)
            0:       return 1'b1;
            1:       return $urandom_range(0, 3) != 0;
            2:       return $urandom_range(0, 3) == 0;
            default: return phase[0];
        endcase
    endfunction

    // ---------------------------------------------------------------- driver
    // bursts of random length, random gaps; valid held until taken

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (in_fire)
                take_record(s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: PAY_W],
                            s_axis_tlast);
            if (!s_axis_tvalid || in_fire) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_records.size() != 0) begin
                    next_req      = pending_records.pop_front();
                    s_axis_tdata  <= {next_req.payload, next_req.score};
                    s_axis_tlast  <= next_req.is_last;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    // stall pattern changes per window: always ready, mostly, rarely, alternating

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
            window_left   <= 0;
            results_seen  <= 0;
        end else begin
            if (out_fire) begin
                check_result();
                results_seen <= results_seen + 1;
            end
            if (window_left == 0) begin
                stall_mode  <= $urandom_range(0, 3);
                window_left <= $urandom_range(20, 80);
            end else begin
                window_left <= window_left - 1;
            end
            m_axis_tready <= (hold_left == 0) && pick_ready(stall_mode, window_left);
        end
    end

    // one long hold in the middle of a sorted run; the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= 30 && m_axis_tvalid && !m_axis_tlast) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (in_fire || out_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int set_no;
        int size;

        // directed sets
        queue_record(32767, 32'hFFFF_FFFF, 1'b1);            // single record
        queue_record(-32768, 32'h0000_0000, 1'b0);           // key extremes
        queue_record(32767, 32'hFFFF_FFFF, 1'b1);
        queue_record(0, 32'h1, 1'b0);                        // all keys equal
        queue_record(0, 32'h2, 1'b0);
        queue_record(0, 32'h3, 1'b1);
        queue_record(100, 32'hA, 1'b0);                      // already descending
        queue_record(50, 32'hB, 1'b0);
        queue_record(0, 32'hC, 1'b0);
        queue_record(-50, 32'hD, 1'b1);
        queue_record(-32768, 32'h5555_5555, 1'b0);           // ascending
        queue_record(-1, 32'hAAAA_AAAA, 1'b0);
        queue_record(0, 32'h0F0F_0F0F, 1'b0);
        queue_record(1, 32'hF0F0_F0F0, 1'b0);
        queue_record(32767, 32'h8000_0001, 1'b1);
        queue_record(5, 32'h11, 1'b0);                       // pairs of ties
        queue_record(-5, 32'h12, 1'b0);
        queue_record(5, 32'h13, 1'b0);
        queue_record(7, 32'h14, 1'b0);
        queue_record(-5, 32'h15, 1'b0);
        queue_record(7, 32'h16, 1'b1);

        // random sets: mostly small, a few full, a few past capacity
        // (one where the tlast request itself arrives with the store full)
        set_no = 0;
        while (items_queued < TARGET_ITEMS) begin
            case (set_no)
                2:       size = CAP;
                5:       size = CAP + 3;
                9:       size = CAP + 1;
                default: begin
                    case ($urandom_range(0, 24))
                        0:       size = CAP;
                        1:       size = $urandom_range(CAP + 1, CAP + 6);
                        default: size = $urandom_range(1, 16);
                    endcase
                end
            endcase
            queue_set(size, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
            set_no++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_records.size() != 0 || s_axis_tvalid || expected_sorted.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
